// File: src/zrt_pkg.sv
// ----------------------------------------------------------------------------
// zrt_pkg
// shared types, sizes and the coefficient tables of the radial table unit
// ----------------------------------------------------------------------------
package zrt_pkg;

  localparam int MAX_ORDERS      = 8;
  localparam int MAX_TERMS       = 8;
  localparam int FRAC_BITS_DEF   = 30;
  localparam int COEF_BITS       = 22;
  localparam int DATA_W          = 32;
  localparam int CNT_W           = 4;
  localparam int IDX_W           = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int TAB_DEPTH       = MAX_ORDERS * MAX_TERMS;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_COUNT = 2'd1;

  typedef enum logic [1:0] {
    COEF_C2,
    COEF_C3,
    COEF_C4
  } coef_sel_t;

  typedef logic signed [DATA_W-1:0] coef_tab_t [TAB_DEPTH];

  // restoring division, used only while building the constant tables
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  // round to nearest of num/den in q22, ties toward +inf
  function automatic logic signed [DATA_W-1:0] ratio_q22(longint num, longint den);
    longint scaled;
    longint d2;
    longint q;
    scaled = num * (64'sd1 <<< (COEF_BITS + 1)) + den;
    d2     = 2 * den;
    if (scaled >= 0) q = longint'(udiv64(scaled, d2));
    else             q = -longint'(udiv64(-scaled + d2 - 1, d2));
    return sat32(q);
  endfunction

  function automatic coef_tab_t build_tab(coef_sel_t sel);
    coef_tab_t t;
    longint m, den, c2n, c3n, c4n;
    for (int n = 0; n < MAX_ORDERS; n++) begin
      for (int s = 0; s < MAX_TERMS; s++) begin
        if (s == 0) begin
          t[n*MAX_TERMS+s] = '0;
        end else if (s == 1) begin
          unique case (sel)
            COEF_C2: t[n*MAX_TERMS+s] = sat32(longint'(n + 2) <<< COEF_BITS);
            COEF_C3: t[n*MAX_TERMS+s] = sat32(-(longint'(n + 1) <<< COEF_BITS));
            default: t[n*MAX_TERMS+s] = '0;
          endcase
        end else begin
          m   = n + 2 * s;
          den = 2 * s * (n + s) * (m - 2);
          c2n = 2 * m * (m - 1) * (m - 2);
          c3n = 2 * m * (m - 1) * (s - 1) * (n + s - 1) - (m - 1) * den;
          c4n = (m - 3) * (c3n + (m - 2) * (den >>> 1))
                - (c2n >>> 1) * (s - 2) * (n + s - 2);
          unique case (sel)
            COEF_C2: t[n*MAX_TERMS+s] = ratio_q22(c2n, den);
            COEF_C3: t[n*MAX_TERMS+s] = ratio_q22(c3n, den);
            default: t[n*MAX_TERMS+s] = ratio_q22(c4n, den);
          endcase
        end
      end
    end
    return t;
  endfunction

  localparam coef_tab_t C2_TAB = build_tab(COEF_C2);
  localparam coef_tab_t C3_TAB = build_tab(COEF_C3);
  localparam coef_tab_t C4_TAB = build_tab(COEF_C4);

endpackage

// File: src/zrt_if.sv
// ----------------------------------------------------------------------------
// zrt_in_if / zrt_out_if
// valid/ready channels carrying the argument and the table values
// ----------------------------------------------------------------------------
interface zrt_in_if
  import zrt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x;

  modport source (output valid, output x, input ready);
  modport sink   (input valid, input x, output ready);
endinterface

interface zrt_out_if
  import zrt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         order_n;
  logic [IDX_W-1:0]         term_s;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output order_n, output term_s, output value,
                  output last, input ready);
  modport sink   (input valid, input order_n, input term_s, input value,
                  input last, output ready);
endinterface

// File: src/zernike_radial_table_unit.sv
// ----------------------------------------------------------------------------
// zernike_radial_table_unit
// zernike radial polynomial table per argument, one shared 32x32 multiplier
// ----------------------------------------------------------------------------
// sequence: once the input transaction is taken the argument is squared and the
//   first value is emitted; each further term takes 3 multiplier passes + emit and
//   each row change a power step more; an emit waits while the output is held;
//   one table at a time on the single shared multiplier; input is not ready while busy
// reset: synchronous active-low, counts return to 8, no output pending
module zernike_radial_table_unit
  import zrt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata,
  zrt_in_if.sink               in_ch,
  zrt_out_if.source            out_ch
);

  localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_F   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint HALF_C   = 64'sd1 <<< (COEF_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] ROWS_MAX  = CNT_W'(MAX_ORDERS);
  localparam logic [CNT_W-1:0] TERMS_MAX = CNT_W'(MAX_TERMS);

  typedef enum logic [2:0] {
    S_IDLE, S_XSQ, S_EMIT, S_COEF, S_MUL_PREV, S_MUL_VBP, S_POWER
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          order_count_r, series_count_r;
  logic [CNT_W-1:0]          rows_r, terms_r;
  logic signed [DATA_W-1:0]  x_r, xsq_r, power_r, prev_r, vbp_r, value_r, a_r;
  logic signed [63:0]        acc_r;
  logic [IDX_W-1:0]          row_r, term_r;
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_order_r, out_term_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic                      out_last_r;

  logic signed [DATA_W-1:0]  mul_a, mul_b;
  logic signed [63:0]        prod;
  logic signed [63:0]        rnd_f, rnd_c, sum;
  logic signed [DATA_W-1:0]  sat_f, sat_c, x_sat;
  logic [IDX_W+IDX_W-1:0]    tab_idx;
  logic                      is_last_term, is_last_row, out_free;

  function automatic logic signed [DATA_W-1:0] sat_unit(logic signed [63:0] v);
    if (v > ONE)  return DATA_W'(ONE);
    if (v < -ONE) return DATA_W'(-ONE);
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] c,
                                                 logic [CNT_W-1:0] hi);
    if (c < CNT_MIN) return CNT_MIN;
    if (c > hi)      return hi;
    return c;
  endfunction

  assign tab_idx = {row_r, term_r};

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      S_XSQ:      begin mul_a = x_r;              mul_b = x_r;   end
      S_COEF:     begin mul_a = C2_TAB[tab_idx];  mul_b = xsq_r; end
      S_MUL_PREV: begin mul_a = a_r;              mul_b = prev_r; end
      S_MUL_VBP:  begin mul_a = C4_TAB[tab_idx];  mul_b = vbp_r; end
      S_POWER:    begin mul_a = power_r;          mul_b = x_r;   end
      default:    begin mul_a = '0;               mul_b = '0;    end
    endcase
  end

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign rnd_f = (prod + HALF_F) >>> FRAC_BITS;
  assign sum   = acc_r + prod;
  assign rnd_c = (sum + HALF_C) >>> COEF_BITS;
  assign sat_f = sat_unit(rnd_f);
  assign sat_c = sat_unit(rnd_c);
  assign x_sat = sat_unit(64'(in_ch.x));

  assign is_last_term = ({1'b0, term_r} + 4'd1) == terms_r;
  assign is_last_row  = ({1'b0, row_r} + 4'd1) == rows_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.order_n = out_order_r;
  assign out_ch.term_s  = out_term_r;
  assign out_ch.value   = out_value_r;
  assign out_ch.last    = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      order_count_r  <= ROWS_MAX;
      series_count_r <= TERMS_MAX;
      out_valid_r    <= 1'b0;
      row_r          <= '0;
      term_r         <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ORDER_COUNT)  order_count_r  <= cfg_wdata;
        if (cfg_index == REG_SERIES_COUNT) series_count_r <= cfg_wdata;
      end
      // the emit state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r     <= x_sat;
            rows_r  <= clamp_cnt(order_count_r, ROWS_MAX);
            terms_r <= clamp_cnt(series_count_r, TERMS_MAX);
            state_r <= S_XSQ;
          end
        end
        S_XSQ: begin
          xsq_r   <= rnd_f[DATA_W-1:0];
          power_r <= DATA_W'(ONE);
          prev_r  <= DATA_W'(ONE);
          value_r <= DATA_W'(ONE);
          vbp_r   <= '0;
          row_r   <= '0;
          term_r  <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_order_r <= row_r;
            out_term_r  <= term_r;
            out_value_r <= value_r;
            out_last_r  <= is_last_term && is_last_row;
            if (!is_last_term) begin
              term_r  <= term_r + IDX_W'(1);
              state_r <= S_COEF;
            end else if (is_last_row) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_POWER;
            end
          end
        end
        S_COEF: begin
          a_r     <= rnd_f[DATA_W-1:0] + C3_TAB[tab_idx];
          state_r <= S_MUL_PREV;
        end
        S_MUL_PREV: begin
          acc_r   <= prod;
          state_r <= S_MUL_VBP;
        end
        S_MUL_VBP: begin
          // acc_r is cleared here so the next product stands alone
          acc_r   <= '0;
          value_r <= sat_c;
          vbp_r   <= prev_r;
          prev_r  <= sat_c;
          state_r <= S_EMIT;
        end
        S_POWER: begin
          power_r <= sat_f;
          prev_r  <= sat_f;
          value_r <= sat_f;
          vbp_r   <= '0;
          row_r   <= row_r + IDX_W'(1);
          term_r  <= '0;
          state_r <= S_EMIT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // acc_r only feeds the sum in S_MUL_VBP, where it was just loaded
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a table is in progress");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r <= DATA_W'(ONE)) && (out_value_r >= DATA_W'(-ONE)))
    else $error("output value outside unit range");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_r != S_XSQ) |->
      ({1'b0, term_r} < terms_r) && ({1'b0, row_r} < rows_r))
    else $error("counter beyond configured table size");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_last_r |-> state_r == S_IDLE)
    else $error("last flag issued before table finished");

endmodule

// File: verif/zernike_radial_table_unit_tb.sv
// ----------------------------------------------------------------------------
// zernike_radial_table_unit_tb
// drives arguments through the radial table unit under random idling on both
// channels and compares every table value against a built-in predictor
// ----------------------------------------------------------------------------
module zernike_radial_table_unit_tb
  import zrt_pkg::*;
;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [IDX_W-1:0]         order_n;
    logic [IDX_W-1:0]         term_s;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } table_value_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    bit                       typed;
    logic signed [DATA_W-1:0] first_power;  // value at row 1, term 0
  } arg_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  zrt_in_if  in_ch ();
  zrt_out_if out_ch ();

  zernike_radial_table_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  longint coef_c2 [MAX_ORDERS][MAX_TERMS];
  longint coef_c3 [MAX_ORDERS][MAX_TERMS];
  longint coef_c4 [MAX_ORDERS][MAX_TERMS];
  logic [CNT_W-1:0] order_cfg = 4'd8;
  logic [CNT_W-1:0] series_cfg = 4'd8;
  table_value_t pending_values [$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_go = 1'b0;
  bit stall_done = 1'b0;
  bit recv_eager = 1'b0;
  bit send_eager = 1'b0;

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q22_of(longint num, longint den);
    return clip32(floor_quot(num * (64'sd1 <<< (COEF_BITS + 1)) + den, 2 * den));
  endfunction

  // nearest, ties up: floor of (v + half) by arithmetic shift
  function automatic longint rshift_round(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic int clip_count(int c);
    if (c < 2) return 2;
    if (c > 8) return 8;
    return c;
  endfunction

  task automatic fill_coefs();
    longint m, den, p2, p3, p4;
    for (int n = 0; n < MAX_ORDERS; n++) begin
      for (int s = 0; s < MAX_TERMS; s++) begin
        if (s == 0) begin
          coef_c2[n][s] = 0; coef_c3[n][s] = 0; coef_c4[n][s] = 0;
        end else if (s == 1) begin
          coef_c2[n][s] = longint'(n + 2) <<< COEF_BITS;
          coef_c3[n][s] = -(longint'(n + 1) <<< COEF_BITS);
          coef_c4[n][s] = 0;
        end else begin
          m   = n + 2 * s;
          den = 2 * s * (n + s) * (m - 2);
          p2  = 2 * m * (m - 1) * (m - 2);
          p3  = 2 * m * (m - 1) * (s - 1) * (n + s - 1) - (m - 1) * den;
          p4  = (m - 3) * (p3 + (m - 2) * (den / 2)) - (p2 / 2) * (s - 2) * (n + s - 2);
          coef_c2[n][s] = q22_of(p2, den);
          coef_c3[n][s] = q22_of(p3, den);
          coef_c4[n][s] = q22_of(p4, den);
        end
      end
    end
  endtask

  // queues the whole table for one argument
  task automatic predict_table(logic signed [DATA_W-1:0] x);
    longint xv, xsq, pw, prev, prev2, a, v;
    int rows, terms;
    table_value_t tv;
    rows  = clip_count(int'(order_cfg));
    terms = clip_count(int'(series_cfg));
    xv  = clip_unit(longint'(x));
    xsq = rshift_round(xv * xv, FRAC_BITS_DEF);
    pw  = ONE_Q;
    for (int n = 0; n < rows; n++) begin
      prev2 = 0;
      prev  = pw;
      for (int s = 0; s < terms; s++) begin
        if (s == 0) begin
          v = prev;
        end else begin
          a = rshift_round(coef_c2[n][s] * xsq, FRAC_BITS_DEF) + coef_c3[n][s];
          v = clip_unit(rshift_round(a * prev + coef_c4[n][s] * prev2, COEF_BITS));
          prev2 = prev;
          prev  = v;
        end
        tv.order_n = n[IDX_W-1:0];
        tv.term_s  = s[IDX_W-1:0];
        tv.value   = v[DATA_W-1:0];
        tv.last    = (n == rows - 1) && (s == terms - 1);
        pending_values.push_back(tv);
      end
      pw = clip_unit(rshift_round(pw * xv, FRAC_BITS_DEF));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // long receiver stall, counted down here
  always @(posedge clk) begin
    if (stall_go && !stall_done) begin
      hold_off   <= 700;
      stall_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // result side: check, then pick the next ready level
  int recv_wait = 0;
  always @(posedge clk) begin
    table_value_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_values.size() == 0) begin
          $display("%0t unexpected value n=%0d s=%0d v=%0d", $time,
                   out_ch.order_n, out_ch.term_s, out_ch.value);
          errors++;
        end else begin
          e = pending_values.pop_front();
          if (out_ch.order_n !== e.order_n || out_ch.term_s !== e.term_s ||
              out_ch.value !== e.value || out_ch.last !== e.last) begin
            $display("%0t mismatch exp n=%0d s=%0d v=%0d l=%0d act n=%0d s=%0d v=%0d l=%0d",
                     $time, e.order_n, e.term_s, e.value, e.last, out_ch.order_n,
                     out_ch.term_s, out_ch.value, out_ch.last);
            errors++;
          end
        end
        recv_wait = recv_eager ? 0 : $urandom_range(0, 13);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ch.ready <= (hold_off == 0) && (recv_wait == 0);
    end
  end

  task automatic offer_arg(logic signed [DATA_W-1:0] x, bit typed,
                           logic signed [DATA_W-1:0] first_power);
    int gap;
    gap = send_eager ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_table(x);
    if (typed && clip_count(int'(order_cfg)) >= 2)
      pending_values[pending_values.size() - clip_count(int'(order_cfg)) *
                     clip_count(int'(series_cfg)) + clip_count(int'(series_cfg))].value =
        first_power;
    in_ch.valid <= 1'b1;
    in_ch.x     <= x;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ORDER_COUNT) order_cfg = val;
    else if (idx == REG_SERIES_COUNT) series_cfg = val;
  endtask

  function automatic logic signed [DATA_W-1:0] random_arg();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'sh40000000 : 32'shc0000000;
      2:       return $signed($urandom_range(0, 4095)) - 2048;
      default: return $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
    endcase
  endfunction

  arg_row_t arg_rows [] = '{
    '{32'sh00000000, 1'b1, 32'sh00000000},
    '{32'sh40000000, 1'b1, 32'sh40000000},
    '{32'shc0000000, 1'b1, 32'shc0000000},
    '{32'sh7fffffff, 1'b1, 32'sh40000000},   // beyond +1.0 saturates
    '{32'sh80000000, 1'b1, 32'shc0000000},   // beyond -1.0 saturates
    '{32'sh40000001, 1'b1, 32'sh40000000},
    '{32'sh00000001, 1'b0, 32'sh0},
    '{32'shffffffff, 1'b0, 32'sh0},
    '{32'sh20000000, 1'b0, 32'sh0},
    '{32'she0000000, 1'b0, 32'sh0},
    '{32'sh2d413ccd, 1'b0, 32'sh0},
    '{32'shd2bec333, 1'b0, 32'sh0},
    '{32'sh3fffffff, 1'b0, 32'sh0},
    '{32'shc0000001, 1'b0, 32'sh0}
  };

  logic [CNT_W-1:0] cfg_sets [][2] = '{
    '{4'd2, 4'd2}, '{4'd8, 4'd8}, '{4'd0, 4'd15}, '{4'd15, 4'd1},
    '{4'd3, 4'd5}, '{4'd1, 4'd0}, '{4'd7, 4'd2}
  };

  initial begin
    fill_coefs();
    in_ch.valid = 1'b0;
    in_ch.x = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset counts, then a small table
    foreach (arg_rows[i]) begin
      offer_arg(arg_rows[i].x, arg_rows[i].typed, arg_rows[i].first_power);
      if (i == 6) begin
        write_reg(REG_ORDER_COUNT, 4'd2);
        write_reg(REG_SERIES_COUNT, 4'd3);
      end
    end
    write_reg(REG_UNUSED, 4'd1);

    for (int ph = 0; ph < cfg_sets.size() + 3; ph++) begin
      if (ph < cfg_sets.size()) begin
        write_reg(REG_ORDER_COUNT, cfg_sets[ph][0]);
        write_reg(REG_SERIES_COUNT, cfg_sets[ph][1]);
      end else begin
        write_reg(REG_ORDER_COUNT, $urandom_range(0, 15));
        write_reg(REG_SERIES_COUNT, $urandom_range(0, 15));
      end
      send_eager = (ph % 3 == 1);
      recv_eager = (ph % 4 == 2);
      // long receiver stall while the sender keeps offering
      if (ph == 3) stall_go = 1'b1;
      repeat (24) offer_arg(random_arg(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/zrt_pkg.sv
src/zrt_if.sv
src/zernike_radial_table_unit.sv
verif/zernike_radial_table_unit_tb.sv
